FILE: rtl/ihsp_pkg.sv
`timescale 1ns / 1ps
// ihsp_pkg: shared types, marker constants and helpers of the image header size parser
// no dependencies

package ihsp_pkg;

  typedef logic [7:0] octet_t;

  localparam int HDR_BYTES = 24;
  localparam int WIN_BYTES = 12;
  localparam int WIN_START = 2;

  // header bytes kept from the start of a file, index 0 is the first byte
  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;
  // segment window, index 0 is the oldest byte
  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_GIF  = 2'd2,
    FMT_PNG  = 2'd3
  } fmt_t;

  // jpeg markers
  localparam octet_t MARK_FF   = 8'hFF;
  localparam octet_t MARK_SOI  = 8'hD8;
  localparam octet_t MARK_APP0 = 8'hE0;
  localparam octet_t SOF_LO_A  = 8'hC0;
  localparam octet_t SOF_HI_A  = 8'hC3;
  localparam octet_t SOF_LO_B  = 8'hC9;
  localparam octet_t SOF_HI_B  = 8'hCB;

  // ascii letters used by the signatures
  localparam octet_t CH_J = 8'h4A;
  localparam octet_t CH_F = 8'h46;
  localparam octet_t CH_I = 8'h49;
  localparam octet_t CH_G = 8'h47;
  localparam octet_t CH_P = 8'h50;
  localparam octet_t CH_N = 8'h4E;
  localparam octet_t CH_H = 8'h48;
  localparam octet_t CH_D = 8'h44;
  localparam octet_t CH_R = 8'h52;

  // png signature bytes that are not letters
  localparam octet_t PNG_SIG0 = 8'h89;
  localparam octet_t PNG_CR   = 8'h0D;
  localparam octet_t PNG_LF   = 8'h0A;
  localparam octet_t PNG_EOF  = 8'h1A;

  // header snapshot handed from the tracker to the decoder
  typedef struct packed {
    logic valid;
    logic long_file;
    hdr_t hdr;
  } snap_t;

  function automatic logic is_sof(input octet_t m);
    return ((m >= SOF_LO_A) && (m <= SOF_HI_A)) || ((m >= SOF_LO_B) && (m <= SOF_HI_B));
  endfunction

endpackage

FILE: rtl/ihsp_byte_if.sv
`timescale 1ns / 1ps
// ihsp_byte_if: valid/ready channel carrying one file byte per transaction
// no dependencies

interface ihsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: rtl/ihsp_size_if.sv
`timescale 1ns / 1ps
// ihsp_size_if: valid/ready channel carrying one size result per transaction
// no dependencies

interface ihsp_size_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  format;
  logic [31:0] width;
  logic [31:0] height;

  modport source (output valid, found, format, width, height, input ready);
  modport sink   (input valid, found, format, width, height, output ready);
endinterface

FILE: rtl/ihsp_tracker.sv
`timescale 1ns / 1ps
// ihsp_tracker: byte position, header store, jpeg segment walk and end-of-file snapshot
// depends on ihsp_pkg

module ihsp_tracker import ihsp_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  octet_t data_byte,
  input  logic   last_byte,
  input  logic   take,
  output snap_t  snap
);

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_MAX   = {PB{1'b1}};
  localparam logic [PB-1:0] POS_FIRST = PB'(WIN_START + WIN_BYTES - 1);
  localparam logic [PB-1:0] POS_HDR   = PB'(HDR_BYTES - 1);
  localparam logic [PB-1:0] WIN_SPAN  = PB'(WIN_BYTES - 1);
  localparam logic [PB-1:0] POS_INIT  = PB'(WIN_START);

  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] next_r, next_nxt;
  logic          walking_r, walking_nxt;
  hdr_t          hdr_r, hdr_nxt;
  win_t          win_r, win_nxt;
  win_t          adopt_r, adopt_nxt;
  logic          snap_valid_r;
  logic          snap_long_r;
  hdr_t          snap_hdr_r;

  logic          at_first;
  logic          jfif;
  logic          adopt_walk;
  logic          stop;
  logic [PB-1:0] pos_m11;
  logic [PB-1:0] apos;
  logic [16:0]   step;
  logic [PB:0]   seg_sum;
  logic [PB-1:0] next_dec;
  hdr_t          snap_hdr;

  // header store write and recent-byte window
  always_comb begin
    hdr_nxt = hdr_r;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (pos_r == PB'(i)) hdr_nxt[i] = data_byte;
    end
    win_nxt = {data_byte, win_r[WIN_BYTES-1:1]};
  end

  // jfif tag check over the header bytes, all stored once the first window is complete
  assign jfif = (hdr_r[0] == MARK_FF) && (hdr_r[1] == MARK_SOI) &&
                (hdr_r[2] == MARK_FF) && (hdr_r[3] == MARK_APP0) &&
                (hdr_r[6] == CH_J) && (hdr_r[7] == CH_F) &&
                (hdr_r[8] == CH_I) && (hdr_r[9] == CH_F);

  // window adoption: first window at its last byte, later ones when their last byte arrives
  assign at_first   = (pos_r == POS_FIRST);
  assign pos_m11    = pos_r - WIN_SPAN;
  assign adopt_walk = walking_r && (next_r == pos_m11);
  assign adopt_nxt  = (at_first || adopt_walk) ? win_nxt : adopt_r;

  // segment decision on the incoming window
  assign stop     = (win_nxt[0] != MARK_FF) || is_sof(win_nxt[1]);
  assign apos     = at_first ? POS_INIT : next_r;
  assign step     = {1'b0, win_nxt[2], win_nxt[3]} + 17'd2;
  assign seg_sum  = {1'b0, apos} + (PB + 1)'(step);
  assign next_dec = seg_sum[PB] ? POS_MAX : seg_sum[PB-1:0];

  always_comb begin
    walking_nxt = walking_r;
    next_nxt    = next_r;
    if (at_first) begin
      walking_nxt = jfif && !stop;
      if (jfif && !stop) next_nxt = next_dec;
    end else if (adopt_walk) begin
      walking_nxt = !stop;
      if (!stop) next_nxt = next_dec;
    end
  end

  // saturating byte position
  assign pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + PB'(1);

  // header as seen at end of file, adopted window over bytes 2 to 13
  always_comb begin
    snap_hdr = hdr_nxt;
    for (int i = 0; i < WIN_BYTES; i++) begin
      snap_hdr[WIN_START + i] = adopt_nxt[i];
    end
  end

  // control state, back to reset after the last byte of a file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      next_r    <= POS_INIT;
      walking_r <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        pos_r     <= '0;
        next_r    <= POS_INIT;
        walking_r <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        next_r    <= next_nxt;
        walking_r <= walking_nxt;
      end
    end
  end

  // byte stores
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r   <= hdr_nxt;
      win_r   <= win_nxt;
      adopt_r <= adopt_nxt;
    end
  end

  // snapshot register toward the decoder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (accept && last_byte) begin
      snap_valid_r <= 1'b1;
    end else if (take) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap_long_r <= (pos_r >= POS_HDR);
      snap_hdr_r  <= snap_hdr;
    end
  end

  assign snap = '{valid: snap_valid_r, long_file: snap_long_r, hdr: snap_hdr_r};

  // end of file restarts the position count
  a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_byte |=> (pos_r == '0) && !walking_r)
    else $error("position not cleared after end of file");

  // the walk starts only after the first window
  a_walk_late: assert property (@(posedge clk) disable iff (!rst_n)
    walking_r |-> (pos_r > POS_FIRST))
    else $error("walk active before first window");

  // the next segment never lies behind the current window
  a_next_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    walking_r |-> (next_r >= pos_m11))
    else $error("next segment passed without adoption");

endmodule

FILE: rtl/ihsp_decoder.sv
`timescale 1ns / 1ps
// ihsp_decoder: format and size decode of a header snapshot into the result register
// depends on ihsp_pkg and ihsp_size_if

module ihsp_decoder import ihsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  snap_t             snap,
  output logic              take,
  ihsp_size_if.source       out_chan
);

  logic        out_valid_r;
  fmt_t        fmt_r, fmt_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  hdr_t        h;

  assign h = snap.hdr;

  // format detection, jpeg then gif then png
  always_comb begin
    fmt_nxt    = FMT_NONE;
    width_nxt  = '0;
    height_nxt = '0;
    if (snap.long_file) begin
      priority if ((h[0] == MARK_FF) && (h[1] == MARK_SOI) && (h[2] == MARK_FF)) begin
        fmt_nxt    = FMT_JPEG;
        height_nxt = {16'd0, h[7], h[8]};
        width_nxt  = {16'd0, h[9], h[10]};
      end else if ((h[0] == CH_G) && (h[1] == CH_I) && (h[2] == CH_F)) begin
        fmt_nxt    = FMT_GIF;
        width_nxt  = {16'd0, h[7], h[6]};
        height_nxt = {16'd0, h[9], h[8]};
      end else if ((h[0] == PNG_SIG0) && (h[1] == CH_P) && (h[2] == CH_N) &&
                   (h[3] == CH_G) && (h[4] == PNG_CR) && (h[5] == PNG_LF) &&
                   (h[6] == PNG_EOF) && (h[7] == PNG_LF) && (h[12] == CH_I) &&
                   (h[13] == CH_H) && (h[14] == CH_D) && (h[15] == CH_R)) begin
        fmt_nxt    = FMT_PNG;
        width_nxt  = {h[16], h[17], h[18], h[19]};
        height_nxt = {h[20], h[21], h[22], h[23]};
      end
    end
  end

  // result register moves when empty or when the current transaction leaves
  assign take = snap.valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fmt_r    <= fmt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.found  = (fmt_r != FMT_NONE);
  assign out_chan.format = fmt_r;
  assign out_chan.width  = width_r;
  assign out_chan.height = height_r;

  // no size is reported without a recognized format
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (fmt_r == FMT_NONE) |-> (width_r == '0) && (height_r == '0))
    else $error("size reported without a format");

  // a short file never yields a format
  a_short_file: assert property (@(posedge clk) disable iff (!rst_n)
    take && !snap.long_file |=> fmt_r == FMT_NONE)
    else $error("format found in a short file");

endmodule

FILE: rtl/image_header_size_parser_unit.sv
`timescale 1ns / 1ps
// image_header_size_parser_unit: top level of the image header size parser
// depends on ihsp_pkg, ihsp_byte_if, ihsp_size_if, ihsp_tracker, ihsp_decoder
//
//   channel   | dir | payload                          | transaction
//   in_chan   | in  | data_byte[7:0], last_byte        | one file byte
//   out_chan  | out | found, format[1:0], width, height | one result per file
//
// One byte per cycle is accepted while in_chan.ready is high; the walk, header store and
// counter update in that cycle. A result goes via the snapshot, then the result register.
// in_chan.ready drops only while both the snapshot and the result register hold results.
// Reset (rst_n low, synchronous) clears position, walk and valid flags; stores need none.
// Files shorter than 24 bytes give found 0.

module image_header_size_parser_unit import ihsp_pkg::*; #(
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ihsp_byte_if.sink   in_chan,
  ihsp_size_if.source out_chan
);

  snap_t snap;
  logic  take;
  logic  accept;

  // input side moves while the snapshot slot is free or being emptied
  assign in_chan.ready = !snap.valid || take;
  assign accept        = in_chan.valid && in_chan.ready;

  ihsp_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_chan.data_byte),
    .last_byte (in_chan.last_byte),
    .take      (take),
    .snap      (snap)
  );

  ihsp_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap     (snap),
    .take     (take),
    .out_chan (out_chan)
  );

  // a waiting snapshot stays until the decoder takes it
  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap.valid && !take |=> snap.valid)
    else $error("pending result dropped");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for image_header_size_parser_unit, byte stream in, sizes out
// depends on ihsp_pkg, ihsp_byte_if, ihsp_size_if and the parser rtl

module testbench;
  import ihsp_pkg::*;

  localparam longint unsigned POS_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int MAX_FILE = 320;
  localparam int RANDOM_BYTES = 580;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_ROWS = 18;

  typedef enum int {
    K_NOISE, K_FILL, K_GIF, K_PNG, K_PNG_BAD, K_JPEG_RAW, K_JFIF
  } file_kind_t;

  // jfif walk shapes
  localparam logic [1:0] WALK_RANDOM = 2'd0;
  localparam logic [1:0] WALK_SOF    = 2'd1;
  localparam logic [1:0] WALK_BREAK  = 2'd2;
  localparam logic [1:0] WALK_TRUNC  = 2'd3;

  typedef struct packed {
    logic        found;
    fmt_t        fmt;
    logic [31:0] w;
    logic [31:0] h;
  } size_rec_t;

  typedef struct packed {
    logic      typed;
    size_rec_t want;
  } file_note_t;

  typedef struct packed {
    file_kind_t  kind;
    logic [15:0] len;
    logic [31:0] w;
    logic [31:0] h;
    logic [1:0]  mode;
    logic        typed;
    size_rec_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ihsp_byte_if in_if ();
  ihsp_size_if out_if ();

  image_header_size_parser_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  octet_t          hdr_q    [HDR_BYTES];
  octet_t          recent_q [WIN_BYTES];
  octet_t          adopt_q  [WIN_BYTES];
  longint unsigned pos_cnt;
  longint unsigned adopt_pos;
  longint unsigned seg_pos;
  bit              walk_on;

  size_rec_t  pending_sizes [$];
  file_note_t file_notes [$];

  // stimulus buffer for one file
  octet_t fbuf [MAX_FILE];
  int     flen;

  dir_row_t dir_rows [N_ROWS];

  int  errors;
  int  cycle_count;
  int  bytes_sent;
  int  bytes_taken;
  int  files_seen;
  int  fmt_seen [4];
  int  in_stalls;
  bit  in_gaps;
  bit  out_gaps;
  bit  hold_ask;

  function automatic bit sof_marker(input octet_t m);
    return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC9 && m <= 8'hCB);
  endfunction

  function automatic void clear_parser();
    for (int i = 0; i < HDR_BYTES; i++) hdr_q[i] = 8'h00;
    for (int i = 0; i < WIN_BYTES; i++) begin
      recent_q[i] = 8'h00;
      adopt_q[i] = 8'h00;
    end
    pos_cnt = 0;
    adopt_pos = 0;
    seg_pos = 2;
    walk_on = 1'b0;
  endfunction

  // byte at file position q, as seen while byte p is the newest
  function automatic octet_t byte_at_pos(input longint unsigned q, input longint unsigned p);
    longint unsigned d;
    if (q < HDR_BYTES) return hdr_q[q];
    if (q > p) return 8'h00;
    d = p - q;
    if (d > 11) return 8'h00;
    return recent_q[11 - d];
  endfunction

  // inspect the adopted window, stop the walk or point at the next segment
  function automatic bit judge_window();
    longint unsigned step;
    if (adopt_q[0] != MARK_FF || sof_marker(adopt_q[1])) begin
      walk_on = 1'b0;
      return 1'b0;
    end
    step = 2 + {adopt_q[2], adopt_q[3]};
    if (adopt_pos > POS_MAX - step) seg_pos = POS_MAX;
    else seg_pos = adopt_pos + step;
    return 1'b1;
  endfunction

  function automatic void follow_segments(input longint unsigned p);
    while (walk_on && seg_pos <= p && p - seg_pos >= 11) begin
      for (int i = 0; i < WIN_BYTES; i++) adopt_q[i] = byte_at_pos(seg_pos + i, p);
      adopt_pos = seg_pos;
      if (!judge_window()) break;
    end
  endfunction

  // one accepted byte; returns 1 with the size result on the last byte of a file
  function automatic bit predict_size(input octet_t b, input logic l, output size_rec_t r);
    longint unsigned p;
    octet_t img [HDR_BYTES];
    p = pos_cnt;
    r = '0;
    if (p < HDR_BYTES) hdr_q[p] = b;
    for (int i = 0; i < WIN_BYTES - 1; i++) recent_q[i] = recent_q[i + 1];
    recent_q[WIN_BYTES - 1] = b;

    if (p == 23) begin
      for (int i = 0; i < WIN_BYTES; i++) adopt_q[i] = hdr_q[i + 2];
      adopt_pos = 2;
      if (hdr_q[0] == MARK_FF && hdr_q[1] == MARK_SOI && hdr_q[2] == MARK_FF &&
          hdr_q[3] == MARK_APP0 && hdr_q[6] == CH_J && hdr_q[7] == CH_F &&
          hdr_q[8] == CH_I && hdr_q[9] == CH_F) begin
        walk_on = 1'b1;
        if (judge_window()) follow_segments(p);
      end
    end else if (p > 23) begin
      follow_segments(p);
    end

    if (pos_cnt < POS_MAX) pos_cnt++;
    if (!l) return 1'b0;

    if (p >= 23) begin
      img = hdr_q;
      for (int i = 0; i < WIN_BYTES; i++) img[i + 2] = adopt_q[i];
      if (img[0] == MARK_FF && img[1] == MARK_SOI && img[2] == MARK_FF) begin
        r.fmt = FMT_JPEG;
        r.h = {16'h0, img[7], img[8]};
        r.w = {16'h0, img[9], img[10]};
      end else if (img[0] == CH_G && img[1] == CH_I && img[2] == CH_F) begin
        r.fmt = FMT_GIF;
        r.w = {16'h0, img[7], img[6]};
        r.h = {16'h0, img[9], img[8]};
      end else if (img[0] == PNG_SIG0 && img[1] == CH_P && img[2] == CH_N &&
                   img[3] == CH_G && img[4] == PNG_CR && img[5] == PNG_LF &&
                   img[6] == PNG_EOF && img[7] == PNG_LF && img[12] == CH_I &&
                   img[13] == CH_H && img[14] == CH_D && img[15] == CH_R) begin
        r.fmt = FMT_PNG;
        r.w = {img[16], img[17], img[18], img[19]};
        r.h = {img[20], img[21], img[22], img[23]};
      end
      r.found = (r.fmt != FMT_NONE);
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void poke(input int idx, input octet_t v);
    if (idx < flen) fbuf[idx] = v;
  endfunction

  // fill fbuf with one file of the given kind
  function automatic void build_file(input file_kind_t kind, input int len,
                                     input logic [31:0] w, input logic [31:0] h,
                                     input logic [1:0] mode);
    int     pos;
    int     seg;
    int     k;
    int     idx;
    octet_t mk;
    flen = len;
    for (int i = 0; i < len; i++) fbuf[i] = octet_t'($urandom_range(0, 255));
    case (kind)
      K_NOISE: begin
      end
      K_FILL: begin
        for (int i = 0; i < len; i++) fbuf[i] = w[7:0];
      end
      K_GIF: begin
        poke(0, CH_G); poke(1, CH_I); poke(2, CH_F);
        poke(6, w[7:0]); poke(7, w[15:8]); poke(8, h[7:0]); poke(9, h[15:8]);
      end
      K_PNG, K_PNG_BAD: begin
        poke(0, PNG_SIG0); poke(1, CH_P); poke(2, CH_N); poke(3, CH_G);
        poke(4, PNG_CR); poke(5, PNG_LF); poke(6, PNG_EOF); poke(7, PNG_LF);
        poke(12, CH_I); poke(13, CH_H); poke(14, CH_D); poke(15, CH_R);
        poke(16, w[31:24]); poke(17, w[23:16]); poke(18, w[15:8]); poke(19, w[7:0]);
        poke(20, h[31:24]); poke(21, h[23:16]); poke(22, h[15:8]); poke(23, h[7:0]);
        // break one signature byte
        if (kind == K_PNG_BAD) begin
          k = $urandom_range(0, 11);
          idx = (k < 8) ? k : k + 4;
          if (idx < flen) fbuf[idx] = fbuf[idx] ^ octet_t'($urandom_range(1, 255));
        end
      end
      K_JPEG_RAW: begin
        poke(0, MARK_FF); poke(1, MARK_SOI); poke(2, MARK_FF);
        // app0 marker but no jfif tag
        if (len > 3 && fbuf[3] == MARK_APP0) poke(6, 8'h00);
        poke(7, h[15:8]); poke(8, h[7:0]); poke(9, w[15:8]); poke(10, w[7:0]);
      end
      K_JFIF: begin
        poke(0, MARK_FF); poke(1, MARK_SOI); poke(2, MARK_FF); poke(3, MARK_APP0);
        seg = (mode == WALK_SOF) ? $urandom_range(6, 8) : $urandom_range(6, 30);
        poke(4, 8'h00); poke(5, octet_t'(seg));
        poke(6, CH_J); poke(7, CH_F); poke(8, CH_I); poke(9, CH_F);
        pos = 4 + seg;
        // chain of segments, ending in a frame marker, a broken marker or the file end
        while (pos + 4 <= flen) begin
          if (mode == WALK_SOF || (mode == WALK_RANDOM && $urandom_range(3) == 0) ||
              (mode == WALK_TRUNC && pos + 12 > flen)) begin
            k = $urandom_range(0, 6);
            mk = (k < 4) ? octet_t'(SOF_LO_A + k) : octet_t'(SOF_LO_B + k - 4);
            poke(pos, MARK_FF); poke(pos + 1, mk);
            poke(pos + 5, h[15:8]); poke(pos + 6, h[7:0]);
            poke(pos + 7, w[15:8]); poke(pos + 8, w[7:0]);
            break;
          end
          if (mode == WALK_BREAK || (mode == WALK_RANDOM && $urandom_range(15) == 0)) begin
            poke(pos, octet_t'($urandom_range(0, 254)));
            break;
          end
          mk = octet_t'($urandom_range(0, 255));
          if (sof_marker(mk)) mk = 8'hE1;
          poke(pos, MARK_FF); poke(pos + 1, mk);
          poke(pos + 2, ($urandom_range(15) == 0) ? octet_t'($urandom_range(0, 255)) : 8'h00);
          poke(pos + 3, octet_t'($urandom_range(2, 24)));
          pos = pos + 2 + {fbuf[pos + 2], fbuf[pos + 3]};
        end
      end
      default: begin
      end
    endcase
  endfunction

  // offer one byte, with random idle cycles ahead of it
  task automatic drive_byte(input octet_t b, input logic l);
    while (in_gaps && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_file(input logic typed, input size_rec_t want);
    file_note_t n;
    n.typed = typed;
    n.want = want;
    file_notes.insert(file_notes.size(), n);
    for (int i = 0; i < flen; i++) begin
      drive_byte(fbuf[i], (i == flen - 1));
      bytes_sent++;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("mismatch %0d at cycle %0d: %s got 0x%0h want 0x%0h",
             errors, cycle_count, what, got, want);
  endtask

  // predict on every accepted input transaction
  always @(posedge clk) begin
    size_rec_t  r;
    file_note_t n;
    if (rst_n && in_if.valid && !in_if.ready) in_stalls++;
    if (rst_n && in_if.valid && in_if.ready) begin
      bytes_taken++;
      if (predict_size(in_if.data_byte, in_if.last_byte, r)) begin
        n = file_notes.pop_front();
        pending_sizes.insert(pending_sizes.size(), n.typed ? n.want : r);
      end
    end
  end

  // compare every accepted result transaction with the oldest expectation
  always @(posedge clk) begin
    size_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_sizes.size() == 0) begin
        note_mismatch("result with nothing expected, width", out_if.width, 32'h0);
      end else begin
        want = pending_sizes.pop_front();
        if (out_if.found !== want.found)
          note_mismatch("found", 32'(out_if.found), 32'(want.found));
        if (out_if.format !== want.fmt)
          note_mismatch("format", 32'(out_if.format), 32'(want.fmt));
        if (out_if.width !== want.w) note_mismatch("width", out_if.width, want.w);
        if (out_if.height !== want.h) note_mismatch("height", out_if.height, want.h);
        files_seen++;
        fmt_seen[want.fmt]++;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_if.ready <= (!out_gaps || $urandom_range(99) >= 19);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_sizes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus
  initial begin
    file_kind_t  kind;
    int          len;
    int          pick;
    logic [31:0] w;
    logic [31:0] h;
    logic [1:0]  mode;

    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.last_byte = 1'b0;
    rst_n = 1'b0;
    errors = 0;
    cycle_count = 0;
    bytes_sent = 0;
    bytes_taken = 0;
    files_seen = 0;
    in_stalls = 0;
    for (int i = 0; i < 4; i++) fmt_seen[i] = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_ask = 1'b0;
    clear_parser();

    // directed files: extremes of each format, short files, jfif walk shapes
    dir_rows[0]  = '{K_NOISE, 16'd1, 32'h0, 32'h0, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[1]  = '{K_GIF, 16'd23, 32'h1, 32'h1, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[2]  = '{K_GIF, 16'd24, 32'hFFFF, 32'h0, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_GIF, 32'hFFFF, 32'h0}};
    dir_rows[3]  = '{K_GIF, 16'd31, 32'h0, 32'hFFFF, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_GIF, 32'h0, 32'hFFFF}};
    dir_rows[4]  = '{K_PNG, 16'd24, 32'hFFFF_FFFF, 32'h0, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_PNG, 32'hFFFF_FFFF, 32'h0}};
    dir_rows[5]  = '{K_PNG, 16'd29, 32'h0, 32'hFFFF_FFFF, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_PNG, 32'h0, 32'hFFFF_FFFF}};
    dir_rows[6]  = '{K_PNG_BAD, 16'd24, 32'h1234_5678, 32'h9ABC_DEF0, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[7]  = '{K_JPEG_RAW, 16'd24, 32'h0, 32'hFFFF, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_JPEG, 32'h0, 32'hFFFF}};
    dir_rows[8]  = '{K_JPEG_RAW, 16'd35, 32'hFFFF, 32'h1, WALK_RANDOM, 1'b1,
                     '{1'b1, FMT_JPEG, 32'hFFFF, 32'h1}};
    dir_rows[9]  = '{K_FILL, 16'd24, 32'h00, 32'h0, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[10] = '{K_FILL, 16'd24, 32'hFF, 32'h0, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[11] = '{K_JFIF, 16'd23, 32'h10, 32'h10, WALK_RANDOM, 1'b1,
                     '{1'b0, FMT_NONE, 32'h0, 32'h0}};
    dir_rows[12] = '{K_JFIF, 16'd24, 32'h1, 32'hFFFF, WALK_SOF, 1'b0, '0};
    dir_rows[13] = '{K_JFIF, 16'd48, 32'hFFFF, 32'hFFFF, WALK_SOF, 1'b0, '0};
    dir_rows[14] = '{K_JFIF, 16'd80, 32'h280, 32'h1E0, WALK_RANDOM, 1'b0, '0};
    dir_rows[15] = '{K_JFIF, 16'd60, 32'h64, 32'h32, WALK_BREAK, 1'b0, '0};
    dir_rows[16] = '{K_JFIF, 16'd40, 32'hABCD, 32'h1234, WALK_TRUNC, 1'b0, '0};
    dir_rows[17] = '{K_JFIF, 16'd120, 32'h0, 32'h0, WALK_TRUNC, 1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      build_file(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].w, dir_rows[i].h,
                 dir_rows[i].mode);
      send_file(dir_rows[i].typed, dir_rows[i].want);
    end

    // sender pauses until every result is back
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_sizes.size() != 0) @(posedge clk);

    // receiver holds off while tiny files keep coming, so the input stalls
    hold_ask = 1'b1;
    for (int i = 0; i < 8; i++) begin
      build_file(K_NOISE, $urandom_range(1, 3), 32'h0, 32'h0, WALK_RANDOM);
      send_file(1'b0, '0);
    end

    // random files, mostly well formed
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      // a stretch with no idling on either side
      in_gaps = !(bytes_sent >= 200 && bytes_sent < 400);
      out_gaps = in_gaps;
      pick = $urandom_range(0, 99);
      len = $urandom_range(24, 40);
      w = $urandom();
      h = $urandom();
      mode = WALK_RANDOM;
      if (pick < 40) begin
        kind = K_JFIF;
        case ($urandom_range(0, 7))
          5: mode = WALK_BREAK;
          6: mode = WALK_TRUNC;
          7: mode = WALK_SOF;
          default: mode = WALK_RANDOM;
        endcase
        len = ($urandom_range(19) == 0) ? $urandom_range(150, 300) : $urandom_range(24, 70);
      end else if (pick < 52) begin
        kind = K_GIF;
      end else if (pick < 64) begin
        kind = K_PNG;
      end else if (pick < 72) begin
        kind = K_JPEG_RAW;
      end else if (pick < 78) begin
        kind = K_PNG_BAD;
      end else if (pick < 88) begin
        kind = K_NOISE;
        len = $urandom_range(1, 40);
      end else if (pick < 94) begin
        // short file of a real format
        case ($urandom_range(0, 3))
          0: kind = K_GIF;
          1: kind = K_PNG;
          2: kind = K_JPEG_RAW;
          default: kind = K_JFIF;
        endcase
        len = $urandom_range(1, 23);
      end else begin
        kind = K_FILL;
        case ($urandom_range(0, 2))
          0: w = 32'h00;
          1: w = 32'hFF;
          default: w = $urandom_range(0, 255);
        endcase
      end
      build_file(kind, len, w, h, mode);
      send_file(1'b0, '0);
    end

    // drain
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d files from %0d bytes: %0d jpeg, %0d gif, %0d png, %0d unknown",
             files_seen, bytes_taken, fmt_seen[FMT_JPEG], fmt_seen[FMT_GIF],
             fmt_seen[FMT_PNG], fmt_seen[FMT_NONE]);
    $display("input held back %0d cycles, %0d mismatches", in_stalls, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
